>>> sv/jdal_pkg.sv
package jdal_pkg;
    localparam int WINDOW = 10;
    localparam int POS_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);

    typedef enum logic [2:0] {
        REG_UP, REG_DOWN, REG_RIGHT, REG_BLINK, REG_HOLD, REG_NONE
    } reg_idx_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0, DIR_UP = 2'd1, DIR_DOWN = 2'd2, DIR_RIGHT = 2'd3
    } dir_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RING, ST_DIV, ST_SCALE, ST_CLASS, ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic ring;
        logic div_start;
        logic scale;
        logic classify;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } stat_t;

    function automatic logic [13:0] wrap_of(input logic [1:0] a);
        case (a)
            2'd0: wrap_of = 14'd2604;
            2'd1: wrap_of = 14'd5208;
            default: wrap_of = 14'd9765;
        endcase
    endfunction

    function automatic logic [13:0] level_of(input logic [1:0] a);
        case (a)
            2'd0: level_of = 14'd2246;
            2'd1: level_of = 14'd3267;
            default: level_of = 14'd3829;
        endcase
    endfunction
endpackage

>>> sv/joystick_average_direction_alert.sv
// Joystick moving-average direction alert.
// s_ channel: one item per sample pair with its millisecond timestamp.
// m_ channel: one result item per input item, in order.
// cfg channel: register writes (index 0..4), taken at any time; write only
// while idle. Indexes beyond 4 are ignored.
// After acceptance, each item passes through the ring update, the
// bit-serial divide by the fill count that produces both means, then
// scaling, classification and output load. A new item is accepted
// only once the previous one has been loaded into the output register.
// The result sits in an output register; the next item is accepted while it
// waits, and processing stalls before output load until it is taken.
// Reset (aresetn low, synchronous) clears the ring fill count, sums, LEDs,
// tone state and restores register defaults. Ring entries are not cleared.
module joystick_average_direction_alert (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // sample_y, sample_x, now_ms
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // mean_y, mean_x, bar_y, bar_x, direction,
                                   // red, green, blue led, tone_wrap, tone_level
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import jdal_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    jdal_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .stat(stat), .cmd(cmd)
    );

    jdal_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .sample_y(s_tdata[11:0]), .sample_x(s_tdata[23:12]), .now_ms(s_tdata[55:24]),
        .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data(cfg_data), .result(m_tdata)
    );
endmodule

>>> sv/jdal_ctrl.sv
module jdal_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  jdal_pkg::stat_t stat,
    output jdal_pkg::cmd_t  cmd
);
    import jdal_pkg::*;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        ov_next = ov_reg;
        if (out_ready) ov_next = 1'b0;
        in_ready = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load = 1'b1;
                    state_next = ST_RING;
                end
            end
            ST_RING: begin
                cmd.ring = 1'b1;
                cmd.div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (stat.div_done) state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale = 1'b1;
                state_next = ST_CLASS;
            end
            ST_CLASS: begin
                cmd.classify = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // output register free or being emptied this cycle
                if (!ov_reg || out_ready) begin
                    cmd.out_load = 1'b1;
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid = ov_reg;

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> state_reg == ST_IDLE) else $error("load outside idle");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg && !out_ready |=> ov_reg) else $error("result dropped");
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !ov_reg || out_ready) else $error("result overrun");
`endif
endmodule

>>> sv/jdal_dp.sv
module jdal_dp (
    input  logic            aclk,
    input  logic            aresetn,
    input  jdal_pkg::cmd_t  cmd,
    output jdal_pkg::stat_t stat,
    input  logic [11:0]     sample_y,
    input  logic [11:0]     sample_x,
    input  logic [31:0]     now_ms,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_idx,
    input  logic [15:0]     cfg_data,
    output logic [71:0]     result
);
    import jdal_pkg::*;

    logic [11:0] up_reg, down_reg, right_reg;
    logic [15:0] blink_reg, hold_reg;
    logic [11:0] ring_y [WINDOW];
    logic [11:0] ring_x [WINDOW];
    logic [11:0] sy_reg, sx_reg, oldy_reg, oldx_reg;
    logic [31:0] now_reg;
    logic [15:0] sum_y_reg, sum_x_reg;
    logic [POS_W-1:0] pos_reg;
    logic [CNT_W-1:0] fill_reg;
    logic full;
    logic [2:0] phase_reg, lit_reg;
    logic [31:0] last_reg [3];
    logic        tact_reg;
    logic [31:0] tend_reg;
    logic [13:0] tper_reg, tcmp_reg;
    // restoring divider, one per axis in parallel, sharing one counter
    logic [15:0] qy_reg, qx_reg, ry_reg, rx_reg;
    logic [4:0]  dcnt_reg;
    logic        dbusy_reg;
    logic [16:0] ry_sh, rx_sh;
    logic [17:0] py_reg, px_reg;
    logic [1:0]  dir;
    logic [11:0] my, mx;
    logic [5:0]  bar_y_reg, bar_x_reg;
    logic [1:0]  dir_reg;
    logic [71:0] res_reg;

    assign full = (fill_reg == CNT_W'(WINDOW));
    assign my = qy_reg[11:0];
    assign mx = qx_reg[11:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_reg <= 12'd3500; down_reg <= 12'd1000; right_reg <= 12'd3500;
            blink_reg <= 16'd200; hold_reg <= 16'd300;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_idx))
                REG_UP:    up_reg    <= cfg_data[11:0];
                REG_DOWN:  down_reg  <= cfg_data[11:0];
                REG_RIGHT: right_reg <= cfg_data[11:0];
                REG_BLINK: blink_reg <= cfg_data;
                REG_HOLD:  hold_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sy_reg <= sample_y; sx_reg <= sample_x; now_reg <= now_ms;
            oldy_reg <= ring_y[pos_reg]; oldx_reg <= ring_x[pos_reg];
        end
        if (cmd.ring) begin
            ring_y[pos_reg] <= sy_reg;
            ring_x[pos_reg] <= sx_reg;
        end
    end

    assign ry_sh = {ry_reg, qy_reg[15]};
    assign rx_sh = {rx_reg, qx_reg[15]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_y_reg <= '0; sum_x_reg <= '0; pos_reg <= '0; fill_reg <= '0;
            dbusy_reg <= 1'b0; dcnt_reg <= '0;
        end else begin
            if (cmd.ring) begin
                sum_y_reg <= sum_y_reg - (full ? {4'd0, oldy_reg} : 16'd0)
                             + {4'd0, sy_reg};
                sum_x_reg <= sum_x_reg - (full ? {4'd0, oldx_reg} : 16'd0)
                             + {4'd0, sx_reg};
                pos_reg <= (pos_reg == POS_W'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;
                if (!full) fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.div_start) begin
                dbusy_reg <= 1'b1; dcnt_reg <= '0;
            end else if (dbusy_reg) begin
                dcnt_reg <= dcnt_reg + 1'b1;
                if (dcnt_reg == 5'd15) dbusy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            qy_reg <= (full ? sum_y_reg - {4'd0, oldy_reg} : sum_y_reg) + {4'd0, sy_reg};
            qx_reg <= (full ? sum_x_reg - {4'd0, oldx_reg} : sum_x_reg) + {4'd0, sx_reg};
            ry_reg <= '0; rx_reg <= '0;
        end else if (dbusy_reg) begin
            if (ry_sh >= 17'(fill_reg)) begin
                ry_reg <= 16'(ry_sh - 17'(fill_reg)); qy_reg <= {qy_reg[14:0], 1'b1};
            end else begin
                ry_reg <= ry_sh[15:0]; qy_reg <= {qy_reg[14:0], 1'b0};
            end
            if (rx_sh >= 17'(fill_reg)) begin
                rx_reg <= 16'(rx_sh - 17'(fill_reg)); qx_reg <= {qx_reg[14:0], 1'b1};
            end else begin
                rx_reg <= rx_sh[15:0]; qx_reg <= {qx_reg[14:0], 1'b0};
            end
        end
    end

    assign stat.div_done = dbusy_reg && (dcnt_reg == 5'd15);

    // bar = mean*50/4095: divide by 4096 with a 1/4096 correction and +1, exact for 12 bits
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            py_reg <= '0; px_reg <= '0;
        end
        if (cmd.scale) begin
            py_reg <= {6'd0, my} * 18'd50;
            px_reg <= {6'd0, mx} * 18'd50;
        end
        if (cmd.classify) begin
            bar_y_reg <= 6'(((py_reg + (py_reg >> 12)) + 18'd1) >> 12);
            bar_x_reg <= 6'(((px_reg + (px_reg >> 12)) + 18'd1) >> 12);
        end
    end

    always_comb begin
        if (my > up_reg) dir = DIR_UP;
        else if (my < down_reg) dir = DIR_DOWN;
        else if (mx > right_reg) dir = DIR_RIGHT;
        else dir = DIR_NONE;
    end

    logic        tend_now;
    logic [1:0]  a;
    logic [31:0] elapsed;
    assign tend_now = tact_reg && ((now_reg - tend_reg) < 32'h8000_0000);
    assign a = dir - 2'd1;
    assign elapsed = now_reg - last_reg[a];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0; lit_reg <= '0; tact_reg <= 1'b0; tend_reg <= '0;
            tper_reg <= '0; tcmp_reg <= '0; dir_reg <= DIR_NONE;
            for (int i = 0; i < 3; i++) last_reg[i] <= '0;
        end else if (cmd.classify) begin
            dir_reg <= dir;
            if (dir == DIR_NONE) begin
                phase_reg <= '0; lit_reg <= '0;
                if (tend_now) begin
                    tact_reg <= 1'b0; tcmp_reg <= '0;
                end
            end else begin
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) != a) lit_reg[i] <= 1'b0;
                end
                if (elapsed < 32'h8000_0000 && elapsed > {16'd0, blink_reg}) begin
                    phase_reg[a] <= ~phase_reg[a];
                    lit_reg[a] <= ~phase_reg[a];
                    last_reg[a] <= now_reg;
                end
                if (!tact_reg || tend_now) begin
                    tper_reg <= wrap_of(a); tcmp_reg <= level_of(a);
                    tend_reg <= now_reg + {16'd0, hold_reg}; tact_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load)
            res_reg <= {3'b000, tcmp_reg, tper_reg, lit_reg[2], lit_reg[1], lit_reg[0],
                        dir_reg, bar_x_reg, bar_y_reg, mx, my};
    end

    assign result = res_reg;
endmodule

>>> verif/tb.sv
module tb;
    import jdal_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    joystick_average_direction_alert dut (.*);

    typedef struct packed {
        logic [11:0] mean_y;
        logic [11:0] mean_x;
        logic [5:0]  bar_y;
        logic [5:0]  bar_x;
        dir_t        dir;
        logic        red;
        logic        green;
        logic        blue;
        logic [13:0] wrap;
        logic [13:0] level;
    } alert_t;

    // register copies
    logic [11:0] thr_up, thr_down, thr_right;
    logic [15:0] blink_ms, hold_ms;
    // joystick state copies
    logic [11:0] hist_y[WINDOW], hist_x[WINDOW];
    logic [15:0] acc_y, acc_x;
    int          wr_pos, filled;
    logic [2:0]  phase_bit, lit;
    logic [31:0] toggled_at[3];
    logic        buzzing;
    logic [31:0] buzz_end;
    logic [13:0] cur_wrap, cur_level;

    logic [55:0] pending_samples[$];
    alert_t      alerts_due[$];
    int          n_fail, n_checked, stall_cnt, gap_cnt;
    bit          sender_hold, rx_block;
    int          dir_seen[4];
    logic [31:0] clk_ms;

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    function automatic bit later_or_same(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d < 32'h8000_0000;
    endfunction

    function automatic void reset_model();
        thr_up = 12'd3500; thr_down = 12'd1000; thr_right = 12'd3500;
        blink_ms = 16'd200; hold_ms = 16'd300;
        acc_y = '0; acc_x = '0; wr_pos = 0; filled = 0;
        phase_bit = '0; lit = '0;
        for (int i = 0; i < 3; i++) toggled_at[i] = '0;
        buzzing = 0; buzz_end = '0; cur_wrap = '0; cur_level = '0;
    endfunction

    function automatic void set_reg(logic [2:0] idx, logic [15:0] val);
        case (reg_idx_t'(idx))
            REG_UP:    thr_up = val[11:0];
            REG_DOWN:  thr_down = val[11:0];
            REG_RIGHT: thr_right = val[11:0];
            REG_BLINK: blink_ms = val;
            REG_HOLD:  hold_ms = val;
            default: ;
        endcase
    endfunction

    function automatic void predict_alert(logic [55:0] item);
        logic [11:0] sy, sx, my, mx;
        logic [31:0] now, el;
        int          a;
        alert_t      r;
        dir_t        d;
        sy = item[11:0]; sx = item[23:12]; now = item[55:24];
        if (filled < WINDOW) filled++;
        else begin
            acc_y = acc_y - hist_y[wr_pos];
            acc_x = acc_x - hist_x[wr_pos];
        end
        hist_y[wr_pos] = sy; hist_x[wr_pos] = sx;
        acc_y = acc_y + sy; acc_x = acc_x + sx;
        wr_pos = (wr_pos + 1) % WINDOW;
        my = 12'(acc_y / filled);
        mx = 12'(acc_x / filled);
        if (buzzing && later_or_same(now, buzz_end)) begin
            buzzing = 0; cur_level = '0;
        end
        if (my > thr_up) d = DIR_UP;
        else if (my < thr_down) d = DIR_DOWN;
        else if (mx > thr_right) d = DIR_RIGHT;
        else d = DIR_NONE;
        dir_seen[d]++;
        if (d == DIR_NONE) begin
            lit = '0; phase_bit = '0;
        end else begin
            a = int'(d) - 1;
            el = now - toggled_at[a];
            if (el < 32'h8000_0000 && el > blink_ms) begin
                phase_bit[a] = ~phase_bit[a];
                lit[a] = phase_bit[a];
                toggled_at[a] = now;
            end
            for (int i = 0; i < 3; i++) if (i != a) lit[i] = 1'b0;
            if (!buzzing) begin
                case (d)
                    DIR_UP:   begin cur_wrap = 14'd2604; cur_level = 14'd2246; end
                    DIR_DOWN: begin cur_wrap = 14'd5208; cur_level = 14'd3267; end
                    default:  begin cur_wrap = 14'd9765; cur_level = 14'd3829; end
                endcase
                buzz_end = now + hold_ms;
                buzzing = 1;
            end
        end
        r.mean_y = my; r.mean_x = mx;
        r.bar_y = 6'(32'(my) * 50 / 4095);
        r.bar_x = 6'(32'(mx) * 50 / 4095);
        r.dir = d; r.red = lit[0]; r.green = lit[1]; r.blue = lit[2];
        r.wrap = cur_wrap; r.level = cur_level;
        alerts_due.push_back(r);
    endfunction

    function automatic void check_alert(logic [71:0] raw);
        alert_t e;
        logic [11:0] gy, gx;
        if (alerts_due.size() == 0) begin
            $error("unexpected result item %h", raw);
            n_fail++;
            return;
        end
        e = alerts_due.pop_front();
        n_checked++;
        gy = raw[11:0]; gx = raw[23:12];
        if (gy !== e.mean_y) begin $error("mean_y exp %0d got %0d", e.mean_y, gy); n_fail++; end
        if (gx !== e.mean_x) begin $error("mean_x exp %0d got %0d", e.mean_x, gx); n_fail++; end
        if (raw[29:24] !== e.bar_y) begin
            $error("bar_y exp %0d got %0d", e.bar_y, raw[29:24]); n_fail++;
        end
        if (raw[35:30] !== e.bar_x) begin
            $error("bar_x exp %0d got %0d", e.bar_x, raw[35:30]); n_fail++;
        end
        if (raw[37:36] !== e.dir) begin
            $error("direction exp %0d got %0d", e.dir, raw[37:36]); n_fail++;
        end
        if (raw[38] !== e.red) begin
            $error("red_led_lit exp %0b got %0b", e.red, raw[38]); n_fail++;
        end
        if (raw[39] !== e.green) begin
            $error("green_led_lit exp %0b got %0b", e.green, raw[39]); n_fail++;
        end
        if (raw[40] !== e.blue) begin
            $error("blue_led_lit exp %0b got %0b", e.blue, raw[40]); n_fail++;
        end
        if (raw[54:41] !== e.wrap) begin
            $error("tone_wrap exp %0d got %0d", e.wrap, raw[54:41]); n_fail++;
        end
        if (raw[68:55] !== e.level) begin
            $error("tone_level exp %0d got %0d", e.level, raw[68:55]); n_fail++;
        end
    endfunction

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end else begin
            if (s_tvalid && s_tready) predict_alert(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                    s_tvalid <= 1'b0;
                end else if (!sender_hold && pending_samples.size() > 0) begin
                    s_tdata <= pending_samples.pop_front();
                    s_tvalid <= 1'b1;
                    gap_cnt = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_alert(m_tdata);
            if (rx_block) begin
                m_tready <= 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 7) == 0) stall_cnt = pick_gap();
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        set_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || s_tvalid || alerts_due.size() > 0)
            @(posedge aclk);
        repeat (25) @(posedge aclk);
    endtask

    function automatic void add_sample(logic [11:0] y, logic [11:0] x, logic [31:0] t);
        pending_samples.push_back({t, x, y});
    endfunction

    // runs of one joystick position so the averages settle into a direction
    function automatic void add_runs(int count);
        int n, zone, len;
        logic [11:0] y, x;
        n = 0;
        while (n < count) begin
            zone = $urandom_range(0, 5);
            len = $urandom_range(1, 25);
            for (int i = 0; i < len; i++) begin
                case (zone)
                    0: begin
                        y = 12'($urandom_range(3600, 4095)); x = 12'($urandom_range(0, 4095));
                    end
                    1: begin
                        y = 12'($urandom_range(0, 900)); x = 12'($urandom_range(0, 4095));
                    end
                    2: begin
                        y = 12'($urandom_range(1500, 2500));
                        x = 12'($urandom_range(3600, 4095));
                    end
                    3: begin
                        y = 12'($urandom_range(1500, 2500));
                        x = 12'($urandom_range(1500, 2500));
                    end
                    4: begin
                        y = 12'($urandom_range(0, 4095)); x = 12'($urandom_range(3000, 4095));
                    end
                    default: begin y = 12'($urandom()); x = 12'($urandom()); end
                endcase
                case ($urandom_range(0, 19))
                    0: clk_ms = $urandom();
                    1: clk_ms = clk_ms - $urandom_range(1, 500);
                    2, 3: clk_ms = clk_ms + $urandom_range(0, 400);
                    default: clk_ms = clk_ms + 50;
                endcase
                add_sample(y, x, clk_ms);
                n++;
            end
        end
    endfunction

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        clk_ms = '0;
        n_fail = 0; n_checked = 0; stall_cnt = 0; gap_cnt = 0;
        sender_hold = 0; rx_block = 0;
        for (int i = 0; i < 4; i++) dir_seen[i] = 0;
        reset_model();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, up and down directions, time wrap, stale holds
        add_sample(12'd4095, 12'd4095, 32'd0);
        add_sample(12'd4095, 12'd0, 32'd100);
        add_sample(12'd4095, 12'd4095, 32'd301);
        add_sample(12'd4095, 12'd4095, 32'd502);
        for (int i = 0; i < 8; i++) add_sample(12'd0, 12'd0, 32'd600 + 250 * i);
        for (int i = 0; i < 6; i++) add_sample(12'd2048, 12'd4095, 32'hFFFF_FF00 + 150 * i);
        add_sample(12'd2048, 12'd4095, 32'h0000_0010);
        add_sample(12'd2048, 12'd2048, 32'h8000_0000);
        add_sample(12'hAAA, 12'h555, 32'h5555_5555);
        add_sample(12'h555, 12'hAAA, 32'hAAAA_AAAA);
        add_sample(12'd2048, 12'd2048, 32'hFFFF_FFFF);
        drain();

        // zero hold and zero blink, thresholds at the extremes
        write_reg(REG_HOLD, 16'd0);
        write_reg(REG_BLINK, 16'd0);
        write_reg(REG_UP, 16'hFFFF);
        write_reg(REG_DOWN, 16'd0);
        write_reg(REG_RIGHT, 16'd0);
        write_reg(REG_NONE, 16'h1234);
        write_reg(3'd7, 16'hFFFF);
        add_runs(150);
        drain();

        write_reg(REG_UP, 16'd0);
        write_reg(REG_DOWN, 16'd4095);
        write_reg(REG_RIGHT, 16'd4095);
        write_reg(REG_BLINK, 16'hFFFF);
        write_reg(REG_HOLD, 16'hFFFF);
        add_runs(150);
        drain();

        write_reg(REG_UP, 16'd3500);
        write_reg(REG_DOWN, 16'd1000);
        write_reg(REG_RIGHT, 16'd3500);
        write_reg(REG_BLINK, 16'd120);
        write_reg(REG_HOLD, 16'd90);
        add_runs(120);
        // receiver holds off while items keep coming
        rx_block = 1;
        repeat (400) @(posedge aclk);
        rx_block = 0;
        drain();
        // sender pauses with results still outstanding
        add_runs(60);
        sender_hold = 1;
        while (alerts_due.size() > 0 || s_tvalid) @(posedge aclk);
        sender_hold = 0;
        add_runs(60);
        drain();

        write_reg(REG_UP, 16'd2600);
        write_reg(REG_DOWN, 16'd1500);
        write_reg(REG_RIGHT, 16'd2600);
        write_reg(REG_BLINK, 16'd30);
        write_reg(REG_HOLD, 16'd400);
        add_runs(280);
        drain();

        $display("tb: %0d results checked; none/up/down/right seen %0d/%0d/%0d/%0d",
                 n_checked, dir_seen[0], dir_seen[1], dir_seen[2], dir_seen[3]);
        if (alerts_due.size() > 0) begin
            $error("%0d expected results never arrived", alerts_due.size());
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #(12 * 2000000);
        $display("tb: FAIL");
        $finish;
    end
endmodule

>>> filelist.f
sv/jdal_pkg.sv
sv/jdal_ctrl.sv
sv/jdal_dp.sv
sv/joystick_average_direction_alert.sv
verif/tb.sv
